/* hw/rtl/nbcp_pkg.sv */
// Package for the nested block cycle profiler.
// Types, sizes and command/status codes shared by the RTL. No dependencies.
`timescale 1ns / 1ps

package nbcp_pkg;

  localparam int ANCHOR_SLOTS = 4096;
  localparam int NEST_DEPTH   = 64;
  localparam int SLOT_W       = $clog2(ANCHOR_SLOTS);
  localparam int STK_W        = $clog2(NEST_DEPTH);
  localparam int SP_W         = $clog2(NEST_DEPTH + 1);

  localparam logic [1:0] CMD_ENTER        = 2'd0;
  localparam logic [1:0] CMD_EXIT         = 2'd1;
  localparam logic [1:0] CMD_EXIT_COUNTED = 2'd2;
  localparam logic [1:0] CMD_READ         = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] anchor_slot;
    logic [63:0] timestamp;
    logic [31:0] inner_add;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] slot_out;
    logic [63:0] exclusive_cycles;
    logic [63:0] inclusive_cycles;
    logic [63:0] hit_total;
    logic [63:0] inner_total;
    logic        counted_mark;
  } result_t;

  typedef struct packed {
    logic [63:0] excl;
    logic [63:0] incl;
    logic [63:0] hits;
    logic [63:0] inner;
    logic        counted;
  } tbl_entry_t;

  typedef struct packed {
    logic [SLOT_W-1:0] parent;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       old_incl;
    logic [63:0]       start;
  } stk_entry_t;

endpackage

/* hw/rtl/nested_block_cycle_profiler_top.sv */
// Top level of the nested block cycle profiler.
// Anchor table and region stack live in on-chip memories; uses nbcp_pkg.
`timescale 1ns / 1ps

// After reset the block clears its anchor table, one entry per cycle, for all
// 4096 entries with busy high. Each accepted transaction then yields exactly
// one result, shown with done for one cycle; the receiver cannot stall. A read
// or an enter passes through S_RD with busy high and then gives its result. An
// exit on an empty stack gives its result in the cycle after start and never
// raises busy. A plain or counted exit passes through S_STK, S_PAR and S_ANC
// with busy high, as the anchor table (one read and one write port) is read and
// written once for the parent and once for the anchor. busy is already low in
// the cycle that done is high, so the next transaction can start while the
// result is still on the ports.
module nested_block_cycle_profiler_top
  import nbcp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output result_t  result,
  output logic     done
);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_STK  = 6'b001000,
    S_PAR  = 6'b010000,
    S_ANC  = 6'b100000
  } state_t;

  state_t state;

  tbl_entry_t tbl_mem [ANCHOR_SLOTS];
  tbl_entry_t tbl_rd;
  tbl_entry_t tbl_wd;
  logic [SLOT_W-1:0] tbl_ra;
  logic [SLOT_W-1:0] tbl_wa;
  logic tbl_we;

  stk_entry_t stk_mem [NEST_DEPTH];
  stk_entry_t stk_rd;
  stk_entry_t stk_wd;
  logic stk_we;
  logic stk_re;

  request_t req;
  logic [SLOT_W-1:0] req_slot;
  logic [SLOT_W-1:0] in_slot;
  logic [SLOT_W-1:0] clr_addr;
  logic [SLOT_W-1:0] parent;
  logic [SP_W-1:0]   sp;
  logic [SP_W-1:0]   sp_top;
  logic [63:0] elapsed;
  logic [63:0] fwd_excl;
  logic fwd;
  logic accept;
  logic full;
  tbl_entry_t par_new;
  tbl_entry_t anc_new;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign in_slot  = SLOT_W'(request.anchor_slot % ANCHOR_SLOTS);
  assign req_slot = SLOT_W'(req.anchor_slot % ANCHOR_SLOTS);
  assign full     = (sp >= SP_W'(NEST_DEPTH));
  assign sp_top   = sp - SP_W'(1);

  always_comb begin
    par_new = tbl_rd;
    par_new.excl = tbl_rd.excl - elapsed;

    anc_new = tbl_rd;
    anc_new.excl = (fwd ? fwd_excl : tbl_rd.excl) + elapsed;
    anc_new.incl = stk_rd.old_incl + elapsed;
    anc_new.hits = tbl_rd.hits + 64'd1;
    anc_new.counted = (req.cmd == CMD_EXIT_COUNTED);
    if (req.cmd == CMD_EXIT_COUNTED) begin
      anc_new.inner = tbl_rd.inner + {32'd0, req.inner_add};
    end
  end

  always_comb begin
    tbl_ra = in_slot;
    tbl_we = 1'b0;
    tbl_wa = clr_addr;
    tbl_wd = '0;
    case (state)
      S_CLR: begin
        tbl_we = 1'b1;
      end
      S_STK: begin
        tbl_ra = stk_rd.parent;
      end
      S_PAR: begin
        tbl_ra = stk_rd.slot;
        tbl_we = 1'b1;
        tbl_wa = stk_rd.parent;
        tbl_wd = par_new;
      end
      S_ANC: begin
        tbl_we = 1'b1;
        tbl_wa = stk_rd.slot;
        tbl_wd = anc_new;
      end
      default: ;
    endcase
  end

  assign stk_re = (state == S_IDLE);
  assign stk_we = (state == S_RD) && (req.cmd == CMD_ENTER) && !full;
  assign stk_wd = '{parent: parent, slot: req_slot, old_incl: tbl_rd.incl,
                    start: req.timestamp};

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_rd <= tbl_mem[tbl_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[sp[STK_W-1:0]] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd <= stk_mem[sp_top[STK_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      sp       <= '0;
      parent   <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + SLOT_W'(1);
          if (clr_addr == SLOT_W'(ANCHOR_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (request.cmd == CMD_READ || request.cmd == CMD_ENTER) begin
              state <= S_RD;
            end else if (sp == '0) begin
              done   <= 1'b1;
              result <= '{status: ST_UNDERFLOW, default: '0};
            end else begin
              state <= S_STK;
            end
          end
        end
        S_RD: begin
          done <= 1'b1;
          result.status <= (req.cmd == CMD_ENTER && full) ? ST_OVERFLOW : ST_OK;
          result.slot_out         <= 12'(req_slot);
          result.exclusive_cycles <= tbl_rd.excl;
          result.inclusive_cycles <= tbl_rd.incl;
          result.hit_total        <= tbl_rd.hits;
          result.inner_total      <= tbl_rd.inner;
          result.counted_mark     <= tbl_rd.counted;
          if (stk_we) begin
            sp     <= sp + SP_W'(1);
            parent <= req_slot;
          end
          state <= S_IDLE;
        end
        S_STK: begin
          state <= S_PAR;
        end
        S_PAR: begin
          state <= S_ANC;
        end
        S_ANC: begin
          done <= 1'b1;
          result.status           <= ST_OK;
          result.slot_out         <= 12'(stk_rd.slot);
          result.exclusive_cycles <= anc_new.excl;
          result.inclusive_cycles <= anc_new.incl;
          result.hit_total        <= anc_new.hits;
          result.inner_total      <= anc_new.inner;
          result.counted_mark     <= anc_new.counted;
          sp     <= sp_top;
          parent <= stk_rd.parent;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
    end
    if (state == S_STK) begin
      elapsed <= req.timestamp - stk_rd.start;
    end
    if (state == S_PAR) begin
      fwd      <= (stk_rd.slot == stk_rd.parent);
      fwd_excl <= par_new.excl;
    end
  end

endmodule
